FILE: hw/rtl/psm_pkg.sv
package psm_pkg;

    localparam int CAPACITY  = 64;
    localparam int MAX_LEN   = 1024;

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int VALUE_W   = 32;
    localparam int OUT_IDX_W = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      first;
    } psm_item_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] item_index;
        logic [OUT_IDX_W-1:0] partner_index;
        logic                 overflow;
    } psm_result_t;

endpackage

FILE: hw/rtl/pair_sum_match_stream.sv
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// item      | item_valid / item_stall    | item   (value, first)
// result    | result_valid / result_stall| result (found, item_index,
//           |                            |         partner_index, overflow)
// target    | target_we                  | target_wdata
//
// One request per cycle while the result is not stalled; a request passes the input
// register, then the parallel compare and store update into the result register.
// The 64-entry associative store updates at the same edge the result loads,
// so the next request always sees it. Reset empties the store and zeroes
// target_sum. A stalled result holds the input register; item_stall rises
// only while both registers are full and the result is stalled.
module pair_sum_match_stream (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  psm_pkg::psm_item_t                 item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output psm_pkg::psm_result_t               result,
    input  logic                               target_we,
    input  logic signed [psm_pkg::VALUE_W-1:0] target_wdata
);

    logic                               in_valid_reg;
    psm_pkg::psm_item_t                 in_data_reg;
    logic signed [psm_pkg::VALUE_W-1:0] target_reg;
    logic                               advance;
    psm_pkg::psm_result_t               cam_result;

    assign item_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            target_reg   <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (target_we)
            begin
                target_reg <= target_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_data_reg <= item;
        end
    end

    psm_cam u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (in_valid_reg && advance),
        .item       (in_data_reg),
        .target_sum (target_reg),
        .result     (cam_result)
    );

    psm_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (in_valid_reg),
        .load_data    (cam_result),
        .ready        (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: hw/rtl/psm_cam.sv
module psm_cam (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               update,
    input  psm_pkg::psm_item_t                 item,
    input  logic signed [psm_pkg::VALUE_W-1:0] target_sum,
    output psm_pkg::psm_result_t               result
);

    logic [psm_pkg::VALUE_W-1:0] entry_value_reg    [psm_pkg::CAPACITY];
    logic [psm_pkg::POS_W-1:0]   entry_position_reg [psm_pkg::CAPACITY];
    logic [psm_pkg::CAPACITY-1:0] entry_valid_reg;
    logic [psm_pkg::CAPACITY-1:0] entry_valid_next;
    logic [psm_pkg::CNT_W-1:0]   next_index_reg;
    logic [psm_pkg::CNT_W-1:0]   next_index_next;
    logic [psm_pkg::FILL_W-1:0]  fill_count_reg;
    logic [psm_pkg::FILL_W-1:0]  fill_count_next;

    // state as seen by this request: a first flag clears it up front
    logic [psm_pkg::CAPACITY-1:0] valid_eff;
    logic [psm_pkg::CNT_W-1:0]    index_eff;
    logic [psm_pkg::FILL_W-1:0]   fill_eff;

    logic signed [psm_pkg::VALUE_W:0] comp;
    logic                              comp_ok;
    logic [psm_pkg::CAPACITY-1:0]      hit_comp;
    logic [psm_pkg::CAPACITY-1:0]      hit_self;
    logic [psm_pkg::POS_W-1:0]         partner;
    logic                              found;
    logic                              saturated;
    logic                              self_hit;
    logic                              store_full;
    logic                              rewrite;
    logic                              insert_new;
    logic [psm_pkg::POS_W-1:0]         idx;
    logic [psm_pkg::SLOT_W-1:0]        slot;

    assign valid_eff = item.first ? '0 : entry_valid_reg;
    assign index_eff = item.first ? '0 : next_index_reg;
    assign fill_eff  = item.first ? '0 : fill_count_reg;

    assign comp    = {target_sum[psm_pkg::VALUE_W-1], target_sum}
                   - {item.value[psm_pkg::VALUE_W-1], item.value};
    assign comp_ok = (comp[psm_pkg::VALUE_W] == comp[psm_pkg::VALUE_W-1]);

    always_comb
    begin
        for (int i = 0; i < psm_pkg::CAPACITY; i++)
        begin
            hit_comp[i] = valid_eff[i] && comp_ok
                       && (entry_value_reg[i] == comp[psm_pkg::VALUE_W-1:0]);
            hit_self[i] = valid_eff[i]
                       && (entry_value_reg[i] == item.value);
        end
    end

    // stored values are distinct, so at most one entry hits: an OR mux suffices
    always_comb
    begin
        partner = '0;
        for (int i = 0; i < psm_pkg::CAPACITY; i++)
        begin
            partner = partner | (hit_comp[i] ? entry_position_reg[i] : '0);
        end
    end

    assign found      = |hit_comp;
    assign self_hit   = |hit_self;
    assign saturated  = (index_eff >= psm_pkg::CNT_W'(psm_pkg::MAX_LEN));
    assign store_full = (fill_eff >= psm_pkg::FILL_W'(psm_pkg::CAPACITY));
    assign idx        = saturated ? psm_pkg::POS_W'(psm_pkg::MAX_LEN - 1)
                                  : index_eff[psm_pkg::POS_W-1:0];
    assign rewrite    = !found && !saturated && self_hit;
    assign insert_new = !found && !saturated && !self_hit && !store_full;
    assign slot       = fill_eff[psm_pkg::SLOT_W-1:0];

    assign result.found         = found;
    assign result.item_index    = psm_pkg::OUT_IDX_W'(idx);
    assign result.partner_index = psm_pkg::OUT_IDX_W'(partner);
    assign result.overflow      = !found && (saturated || (!self_hit && store_full));

    always_comb
    begin
        entry_valid_next = valid_eff;
        if (insert_new)
        begin
            entry_valid_next[slot] = 1'b1;
        end
        fill_count_next = insert_new ? fill_eff + 1'b1 : fill_eff;
        next_index_next = saturated ? index_eff : index_eff + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            next_index_reg  <= '0;
            fill_count_reg  <= '0;
        end
        else if (update)
        begin
            entry_valid_reg <= entry_valid_next;
            next_index_reg  <= next_index_next;
            fill_count_reg  <= fill_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            for (int i = 0; i < psm_pkg::CAPACITY; i++)
            begin
                if (rewrite && hit_self[i])
                begin
                    entry_position_reg[i] <= idx;
                end
                else if (insert_new && (slot == psm_pkg::SLOT_W'(i)))
                begin
                    entry_value_reg[i]    <= item.value;
                    entry_position_reg[i] <= idx;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/psm_out_reg.sv
module psm_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    input  psm_pkg::psm_result_t load_data,
    output logic                 ready,
    output logic                 result_valid,
    input  logic                 result_stall,
    output psm_pkg::psm_result_t result
);

    logic                 valid_reg;
    psm_pkg::psm_result_t data_reg;

    assign ready        = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load_valid)
        begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: tb/sv/pair_sum_match_stream_tb.sv
module pair_sum_match_stream_tb;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               item_valid = 1'b0;
    logic                               item_stall;
    psm_pkg::psm_item_t                 item = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    psm_pkg::psm_result_t               result;
    logic                               target_we = 1'b0;
    logic signed [psm_pkg::VALUE_W-1:0] target_wdata = '0;

    // predictor state
    logic signed [psm_pkg::VALUE_W-1:0] target_model;
    logic [psm_pkg::VALUE_W-1:0]        slot_value [psm_pkg::CAPACITY];
    logic [psm_pkg::POS_W-1:0]          slot_pos [psm_pkg::CAPACITY];
    logic                               slot_used [psm_pkg::CAPACITY];
    int                                 set_count;
    int                                 slots_filled;

    psm_pkg::psm_result_t               pending_results [$];
    logic signed [psm_pkg::VALUE_W-1:0] recent_values [$];

    bit idle_on = 1'b1;
    int error_count = 0;
    int request_count = 0;
    int set_total = 0;
    int match_total = 0;
    int dropped_total = 0;
    int saturated_total = 0;

    pair_sum_match_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .target_we    (target_we),
        .target_wdata (target_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void clear_store_model();
        for (int s = 0; s < psm_pkg::CAPACITY; s++)
        begin
            slot_used[s]  = 1'b0;
            slot_value[s] = '0;
            slot_pos[s]   = '0;
        end
        set_count    = 0;
        slots_filled = 0;
    endfunction

    // Computes the expected match report for one request and updates the store.
    function automatic psm_pkg::psm_result_t predict_match(input psm_pkg::psm_item_t it);
        psm_pkg::psm_result_t r;
        logic signed [32:0]   comp;
        logic                 sat;
        logic                 placed;
        r = '0;
        if (it.first)
        begin
            clear_store_model();
            set_total++;
        end
        sat = (set_count >= psm_pkg::MAX_LEN);
        r.item_index = sat ? psm_pkg::OUT_IDX_W'(psm_pkg::MAX_LEN - 1)
                           : psm_pkg::OUT_IDX_W'(set_count);
        comp = {target_model[psm_pkg::VALUE_W-1], target_model}
             - {it.value[psm_pkg::VALUE_W-1], it.value};
        // complement outside 32-bit signed range can never match
        if (comp[32] == comp[31])
        begin
            for (int s = 0; s < psm_pkg::CAPACITY; s++)
                if (!r.found && slot_used[s] && slot_value[s] == comp[31:0])
                begin
                    r.found         = 1'b1;
                    r.partner_index = slot_pos[s];
                end
        end
        if (!r.found)
        begin
            if (sat)
                r.overflow = 1'b1;
            else
            begin
                placed = 1'b0;
                for (int s = 0; s < psm_pkg::CAPACITY; s++)
                    if (!placed && slot_used[s] && slot_value[s] == it.value)
                    begin
                        slot_pos[s] = psm_pkg::POS_W'(set_count);
                        placed      = 1'b1;
                    end
                if (!placed)
                begin
                    if (slots_filled < psm_pkg::CAPACITY)
                    begin
                        slot_value[slots_filled] = it.value;
                        slot_pos[slots_filled]   = psm_pkg::POS_W'(set_count);
                        slot_used[slots_filled]  = 1'b1;
                        slots_filled++;
                    end
                    else
                        r.overflow = 1'b1;
                end
            end
        end
        if (!sat)
            set_count++;
        match_total     += r.found;
        dropped_total   += r.overflow;
        saturated_total += sat;
        return r;
    endfunction

    // Sends one request; valid stays high on return so back-to-back requests
    // need no extra assignment.
    task automatic push_value(input logic signed [psm_pkg::VALUE_W-1:0] v,
                              input logic f);
        psm_pkg::psm_item_t   it;
        psm_pkg::psm_result_t want;
        it.value = v;
        it.first = f;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        want = predict_match(it);
        pending_results.insert(pending_results.size(), want);
        request_count++;
    endtask

    task automatic drain_results();
        if (item_valid)
            item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_target(input logic signed [psm_pkg::VALUE_W-1:0] v);
        drain_results();
        target_we    <= 1'b1;
        target_wdata <= v;
        @(posedge clk);
        target_we    <= 1'b0;
        target_model = v;
    endtask

    // Biased toward complements and repeats of recent values so matches and
    // overwrites are frequent.
    function automatic logic signed [psm_pkg::VALUE_W-1:0] pick_value();
        logic signed [32:0]                 comp;
        logic signed [psm_pkg::VALUE_W-1:0] r;
        int                                 sel;
        sel = $urandom_range(0, 99);
        r   = (recent_values.size() != 0) ?
              recent_values[$urandom_range(0, recent_values.size() - 1)] : '0;
        if (sel < 35 && recent_values.size() != 0)
        begin
            comp = {target_model[psm_pkg::VALUE_W-1], target_model}
                 - {r[psm_pkg::VALUE_W-1], r};
            if (comp[32] == comp[31])
                return comp[31:0];
            return $urandom;
        end
        if (sel < 55 && recent_values.size() != 0)
            return r;
        if (sel < 70)
            return $urandom;
        if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $signed($urandom_range(0, 100)) - 50;
    endfunction

    task automatic push_random(input logic f);
        logic signed [psm_pkg::VALUE_W-1:0] v;
        if (f)
            recent_values.delete();
        v = pick_value();
        push_value(v, f);
        recent_values.insert(recent_values.size(), v);
        if (recent_values.size() > 64)
            void'(recent_values.pop_front());
    endtask

    function automatic logic signed [psm_pkg::VALUE_W-1:0] pick_target();
        if ($urandom_range(0, 1) == 0)
            return $signed($urandom_range(0, 100)) - 50;
        return $urandom;
    endfunction

    task automatic test_directed_extremes();
        // target at its reset value of zero
        push_value(32'sd0, 1'b1);
        push_value(32'sd0, 1'b0);
        push_value(32'h7fff_ffff, 1'b0);
        push_value(32'h8000_0001, 1'b0);
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h8000_0000, 1'b0);
        write_target(32'h7fff_ffff);
        push_value(-32'sd1, 1'b1);
        push_value(32'h7fff_ffff, 1'b0);
        push_value(32'sd0, 1'b0);
        write_target(32'h8000_0000);
        push_value(32'sd1, 1'b1);
        push_value(32'h8000_0000, 1'b0);
        push_value(32'sd0, 1'b0);
        push_value(-32'sd1, 1'b0);
        push_value(32'h5555_5555, 1'b0);
        push_value(32'haaaa_aaaa, 1'b0);
        // repeated value moves its index; the later match must see the new one
        write_target(32'sd10);
        push_value(32'sd3, 1'b1);
        push_value(32'sd3, 1'b0);
        push_value(32'sd7, 1'b0);
    endtask

    task automatic test_store_full();
        write_target(32'sd0);
        push_value(32'sd1, 1'b1);
        for (int n = 2; n <= psm_pkg::CAPACITY; n++)
            push_value(n, 1'b0);
        push_value(32'sd100, 1'b0);
        push_value(32'sd5, 1'b0);
        push_value(-32'sd3, 1'b0);
        push_value(32'sd200, 1'b0);
    endtask

    task automatic test_random_sets();
        for (int n = 0; n < 350; n++)
        begin
            if (n % 100 == 0)
                write_target(pick_target());
            else if ($urandom_range(0, 199) == 0)
                drain_results();
            push_random(n == 0 || $urandom_range(0, 24) == 0);
        end
    endtask

    // One set long enough to saturate the index, with the store filling on the way.
    task automatic test_long_set_saturation();
        for (int n = 0; n < 1100; n++)
        begin
            if (n % 300 == 0)
                write_target(pick_target());
            if (n == 900)
                idle_on = 1'b0;
            push_random(n == 0);
        end
    endtask

    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n || !idle_on)
        begin
            stall_left = 0;
            result_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        psm_pkg::psm_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (result.found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b (item_index %0d)",
                                              result.found, want.found, want.item_index));
                if (result.item_index !== want.item_index)
                    report_mismatch($sformatf("item_index %0d, expected %0d",
                                              result.item_index, want.item_index));
                if (result.partner_index !== want.partner_index)
                    report_mismatch($sformatf("partner_index %0d, expected %0d (item_index %0d)",
                                              result.partner_index, want.partner_index,
                                              want.item_index));
                if (result.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, expected %0b (item_index %0d)",
                                              result.overflow, want.overflow, want.item_index));
            end
        end
    end

    initial
    begin
        #(20 * 400000);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        clear_store_model();
        target_model = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_store_full();
        test_random_sets();
        test_long_set_saturation();
        drain_results();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("requests left without a result");
        $display("Ran %0d requests over %0d sets: %0d matches, %0d dropped inserts,",
                 request_count, set_total, match_total, dropped_total);
        $display("%0d requests at the saturated index, with target extremes and a full store.",
                 saturated_total);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/psm_pkg.sv
hw/rtl/psm_cam.sv
hw/rtl/psm_out_reg.sv
hw/rtl/pair_sum_match_stream.sv
tb/sv/pair_sum_match_stream_tb.sv
